// ----- hdl/sdt_pkg.sv -----
// Shared types and codes for the seen-device table.
package sdt_pkg;

	localparam int ADDR_W  = 48;
	localparam int KIND_W  = 8;
	localparam int RSSI_W  = 8;
	localparam int STAMP_W = 40;
	localparam int SLOT_W  = 6;

	localparam logic OP_OBSERVE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	typedef struct packed {
		logic                      opcode;
		logic [ADDR_W-1:0]         device_address;
		logic [KIND_W-1:0]         device_address_kind;
		logic signed [RSSI_W-1:0]  signal_strength;
		logic [STAMP_W-1:0]        now_stamp;
		logic [SLOT_W-1:0]         read_slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]         slot;
		logic                      hit;
		logic                      evicted;
		logic                      entry_valid;
		logic [ADDR_W-1:0]         entry_address;
		logic [KIND_W-1:0]         entry_address_kind;
		logic signed [RSSI_W-1:0]  entry_strength;
		logic [STAMP_W-1:0]        entry_stamp;
	} rsp_t;

	typedef struct packed {
		logic                      valid;
		logic [ADDR_W-1:0]         address;
		logic [KIND_W-1:0]         kind;
		logic signed [RSSI_W-1:0]  strength;
		logic [STAMP_W-1:0]        stamp;
	} entry_t;

	// Probe that walks the cell chain, one cell per cycle.
	typedef struct packed {
		logic   active;
		logic   first;
		logic   hit;
		req_t   req;
		entry_t pick;
	} probe_t;

	typedef struct packed {
		logic   en;
		entry_t ent;
	} wr_t;

endpackage

// ----- hdl/sdt_cell.sv -----
// One table entry and its stage of the probe chain.
module sdt_cell #(
	parameter int ENTRIES = 64,
	parameter int IDX     = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sdt_pkg::probe_t               prb_in,
	input  logic [$clog2(ENTRIES)-1:0]    idx_in,
	output sdt_pkg::probe_t               prb_out,
	output logic [$clog2(ENTRIES)-1:0]    idx_out,
	input  sdt_pkg::wr_t                  wr,
	input  logic [$clog2(ENTRIES)-1:0]    wr_idx
);
	import sdt_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	entry_t        ent_q;
	probe_t        prb_nxt;
	logic [IW-1:0] idx_nxt;
	probe_t        prb_q;
	logic [IW-1:0] idx_q;

	always_comb begin
		prb_nxt = prb_in;
		idx_nxt = idx_in;
		prb_nxt.first = 1'b0;
		if (prb_in.active) begin
			case (prb_in.req.opcode)
				OP_READ: begin
					if (IDX == int'(prb_in.req.read_slot)) begin
						prb_nxt.pick = ent_q;
					end
				end
				OP_OBSERVE: begin
					// Once a matching entry is found the rest of the chain leaves the probe alone.
					if (!prb_in.hit) begin
						if (ent_q.valid && ent_q.address == prb_in.req.device_address) begin
							prb_nxt.pick = ent_q;
							prb_nxt.hit  = 1'b1;
							idx_nxt      = MY_IDX;
						end else if (prb_in.first || !ent_q.valid ||
							ent_q.stamp < prb_in.pick.stamp) begin
							prb_nxt.pick = ent_q;
							idx_nxt      = MY_IDX;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
			prb_q <= '0;
			idx_q <= '0;
		end else begin
			if (wr.en && wr_idx == MY_IDX) begin
				ent_q <= wr.ent;
			end
			prb_q <= prb_nxt;
			idx_q <= idx_nxt;
		end
	end

	assign prb_out = prb_q;
	assign idx_out = idx_q;

endmodule

// ----- hdl/seen_device_table_oldest_replace.sv -----
// Seen-device table: chain of entry cells scanned by a travelling probe.
//
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | req_data (sdt_pkg::req_t)
//  result  | rsp_valid | rsp_stall | rsp_data (sdt_pkg::rsp_t)
//
// A request walks the row of TABLE_ENTRIES cells, one cell per cycle, and the next
// request is taken only once that scan has ended and its result has moved on to the
// output register; the chain length sets how long this wait is.
// The result leaves through an output register, so the next request is taken
// while an earlier result is stalled; it holds the request side only when that
// result is still stalled as the following scan ends. Reset clears every entry at once.
module seen_device_table_oldest_replace #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sdt_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sdt_pkg::rsp_t  rsp_data
);
	import sdt_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);

	probe_t        prb [0:TABLE_ENTRIES];
	logic [IW-1:0] idx [0:TABLE_ENTRIES];
	wr_t           wr;
	logic [IW-1:0] wr_idx;
	probe_t        tail;
	rsp_t          res;

	logic scan_q;
	logic pend_v_q;
	logic rsp_valid_q;
	rsp_t pend_q;
	rsp_t rsp_q;

	logic accept;

	assign accept    = req_valid && !req_stall;
	assign req_stall = scan_q;

	always_comb begin
		prb[0]        = '0;
		prb[0].active = accept;
		prb[0].first  = 1'b1;
		prb[0].req    = req_data;
		idx[0]        = '0;
	end

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		sdt_cell #(
			.ENTRIES (TABLE_ENTRIES),
			.IDX     (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.prb_in  (prb[g]),
			.idx_in  (idx[g]),
			.prb_out (prb[g+1]),
			.idx_out (idx[g+1]),
			.wr      (wr),
			.wr_idx  (wr_idx)
		);
	end

	assign tail = prb[TABLE_ENTRIES];

	// For an observe, the picked slot is rewritten in the same cycle the probe leaves the chain.
	always_comb begin
		wr.en           = tail.active && tail.req.opcode == OP_OBSERVE;
		wr.ent.valid    = 1'b1;
		wr.ent.address  = tail.req.device_address;
		wr.ent.kind     = tail.req.device_address_kind;
		wr.ent.strength = tail.req.signal_strength;
		wr.ent.stamp    = tail.req.now_stamp;
		wr_idx          = idx[TABLE_ENTRIES];
	end

	always_comb begin
		res.entry_valid        = tail.pick.valid;
		res.entry_address      = tail.pick.address;
		res.entry_address_kind = tail.pick.kind;
		res.entry_strength     = tail.pick.strength;
		res.entry_stamp        = tail.pick.stamp;
		if (tail.req.opcode == OP_READ) begin
			res.slot    = tail.req.read_slot;
			res.hit     = 1'b0;
			res.evicted = 1'b0;
		end else begin
			res.slot    = SLOT_W'(idx[TABLE_ENTRIES]);
			res.hit     = tail.hit;
			res.evicted = tail.pick.valid &&
				tail.pick.address != tail.req.device_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				scan_q <= 1'b1;
			end
			if (tail.active) begin
				pend_v_q <= 1'b1;
			end
			if (pend_v_q && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
				pend_v_q    <= 1'b0;
				scan_q      <= 1'b0;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.active) begin
			pend_q <= res;
		end
		if (pend_v_q && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q <= pend_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.active |-> scan_q && !pend_v_q)
		else $error("probe left the chain outside a scan");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> scan_q)
		else $error("accepted request did not start a scan");

	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> scan_q)
		else $error("pending result without a scan in progress");

	a_rsp_from_pend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(pend_v_q))
		else $error("result raised without a pending result");

endmodule

// ----- dv/sdt_table_scoreboard_pkg.sv -----
// Scoreboard that predicts and checks the results of the seen-device table.
package sdt_table_scoreboard_pkg;
	import sdt_pkg::*;

	localparam int TABLE_DEPTH = 64;

	class device_table_scoreboard;
		entry_t devices[TABLE_DEPTH];
		rsp_t   awaited_results[$];
		int     mismatches;
		int     observe_count;
		int     read_count;
		int     refresh_count;
		int     replace_count;

		function new();
			foreach (devices[i]) devices[i] = '0;
			mismatches    = 0;
			observe_count = 0;
			read_count    = 0;
			refresh_count = 0;
			replace_count = 0;
		endfunction

		function int outstanding();
			return awaited_results.size();
		endfunction

		// Works out the result of an accepted request and updates the table copy.
		function void note_request(req_t req);
			rsp_t   res;
			entry_t prior;
			int     idx;
			logic   matched;
			res     = '0;
			matched = 1'b0;
			idx     = 0;
			if (req.opcode == OP_READ) begin
				idx = int'(req.read_slot);
				read_count++;
			end else begin
				// A matching used entry ends the scan; otherwise an unused slot or
				// a strictly older stamp takes over the pick.
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (devices[i].valid && devices[i].address == req.device_address) begin
						idx     = i;
						matched = 1'b1;
						break;
					end
					if (!devices[i].valid || devices[i].stamp < devices[idx].stamp)
						idx = i;
				end
				observe_count++;
			end
			prior                  = devices[idx];
			res.slot               = SLOT_W'(idx);
			res.entry_valid        = prior.valid;
			res.entry_address      = prior.address;
			res.entry_address_kind = prior.kind;
			res.entry_strength     = prior.strength;
			res.entry_stamp        = prior.stamp;
			if (req.opcode == OP_OBSERVE) begin
				res.hit     = matched;
				res.evicted = prior.valid && prior.address != req.device_address;
				if (res.hit)
					refresh_count++;
				if (res.evicted)
					replace_count++;
				devices[idx].valid    = 1'b1;
				devices[idx].address  = req.device_address;
				devices[idx].kind     = req.device_address_kind;
				devices[idx].strength = req.signal_strength;
				devices[idx].stamp    = req.now_stamp;
			end
			awaited_results.push_back(res);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			mismatches++;
			$display("mismatch %s: got %h, expected %h", what, got, want);
		endtask

		task compare(string field, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report(field, got, want);
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			if (awaited_results.size() == 0) begin
				report("result with no request outstanding, slot", 64'(got.slot), '0);
				return;
			end
			want = awaited_results.pop_front();
			compare("slot", 64'(got.slot), 64'(want.slot));
			compare("hit", 64'(got.hit), 64'(want.hit));
			compare("evicted", 64'(got.evicted), 64'(want.evicted));
			compare("entry_valid", 64'(got.entry_valid), 64'(want.entry_valid));
			compare("entry_address", 64'(got.entry_address), 64'(want.entry_address));
			compare("entry_address_kind", 64'(got.entry_address_kind),
				64'(want.entry_address_kind));
			compare("entry_strength", {56'b0, got.entry_strength},
				{56'b0, want.entry_strength});
			compare("entry_stamp", 64'(got.entry_stamp), 64'(want.entry_stamp));
		endtask
	endclass

endpackage

// ----- dv/testbench.sv -----
// Top-level testbench for the seen-device table with oldest-stamp replacement.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sdt_pkg::*;
	import sdt_table_scoreboard_pkg::*;

	localparam int RANDOM_REQUESTS = 1750;
	localparam int PHASE_LENGTH    = 150;
	localparam int CYCLE_LIMIT     = 800000;
	localparam int DRAIN_CYCLES    = 200;
	localparam int HOLD_OFF_CYCLES = 500;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	logic rsp_valid;
	req_t req_data  = '0;
	rsp_t rsp_data;

	int sent_count = 0;

	device_table_scoreboard scoreboard = new();

	seen_device_table_oldest_replace #(
		.TABLE_ENTRIES(TABLE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	always #5ns clk = ~clk;

	// Every fourth stretch of requests runs with no idle cycles at all.
	function automatic int draw_gap(int seq);
		if ((seq / 120) % 4 == 3)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic logic [ADDR_W-1:0] random_address();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return ADDR_W'({$urandom, $urandom});
		endcase
	endfunction

	function automatic req_t observe_req(logic [ADDR_W-1:0] addr, logic [KIND_W-1:0] kind,
			logic signed [RSSI_W-1:0] strength, logic [STAMP_W-1:0] stamp);
		req_t req;
		req.opcode              = OP_OBSERVE;
		req.device_address      = addr;
		req.device_address_kind = kind;
		req.signal_strength     = strength;
		req.now_stamp           = stamp;
		req.read_slot           = SLOT_W'($urandom);
		return req;
	endfunction

	// The observe fields of a read carry noise; the block must ignore them.
	function automatic req_t read_req(logic [SLOT_W-1:0] slot);
		req_t req;
		req           = observe_req(random_address(), KIND_W'($urandom), RSSI_W'($urandom),
			STAMP_W'({$urandom, $urandom}));
		req.opcode    = OP_READ;
		req.read_slot = slot;
		return req;
	endfunction

	task automatic send_request(input req_t req);
		int gap;
		gap = draw_gap(sent_count);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= req;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		scoreboard.note_request(req);
		sent_count++;
	endtask

	initial begin : result_sink
		int gap;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			// Twice in the run the sink holds off long enough for the block to
			// back up and stall its request side.
			gap = (taken == 300 || taken == 1200) ? HOLD_OFF_CYCLES : draw_gap(taken);
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			scoreboard.check_result(rsp_data);
			taken++;
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		logic [ADDR_W-1:0]  pool[128];
		logic [STAMP_W-1:0] clock_ms;
		logic [STAMP_W-1:0] stamp;
		int                 pool_size;
		int                 stamp_mode;
		int                 pick;
		int                 issued;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: cleared table, field extremes, refreshes and reads.
		send_request(read_req(6'd0));
		send_request(read_req(6'd63));
		send_request(observe_req('0, 8'h00, -8'sd128, '0));
		send_request(observe_req('1, 8'hFF, 8'sd127, '1));
		send_request(observe_req('0, 8'h5A, -8'sd1, 40'd5));
		send_request(observe_req(48'hAAAA_AAAA_AAAA, 8'hAA, 8'sh55, 40'hAA_AAAA_AAAA));
		send_request(observe_req(48'h5555_5555_5555, 8'h55, 8'shAA, 40'h55_5555_5555));
		send_request(observe_req('1, 8'h01, 8'sd0, '0));
		send_request(observe_req(48'h0000_0000_0001, 8'h80, 8'sd1, 40'd5));
		send_request(observe_req(48'h8000_0000_0000, 8'h7F, -8'sd2, 40'd5));
		send_request(read_req(6'd63));
		send_request(read_req(6'd62));
		send_request(read_req(6'd61));
		send_request(read_req(6'd31));
		send_request(read_req(6'd0));
		send_request(observe_req(48'h5555_5555_5555, 8'h33, 8'sd100, 40'd4));
		send_request(read_req(6'd60));

		// Random part: phases of pooled addresses so that the table fills, entries
		// get refreshed and the oldest ones get replaced.
		clock_ms = '0;
		issued   = 0;
		while (issued < RANDOM_REQUESTS) begin
			case ($urandom_range(0, 5))
				0:       pool_size = 6;
				1:       pool_size = 40;
				2:       pool_size = 64;
				3:       pool_size = 65;
				4:       pool_size = 90;
				default: pool_size = 128;
			endcase
			stamp_mode = $urandom_range(0, 3);
			foreach (pool[i]) pool[i] = random_address();
			for (int k = 0; k < PHASE_LENGTH && issued < RANDOM_REQUESTS; k++) begin
				case (stamp_mode)
					0: begin
						clock_ms = clock_ms + STAMP_W'($urandom_range(0, 2000));
						stamp    = clock_ms;
					end
					1:       stamp = STAMP_W'({$urandom, $urandom});
					2:       stamp = STAMP_W'($urandom_range(0, 3));
					default: stamp = '1 - STAMP_W'($urandom_range(0, 15));
				endcase
				pick = $urandom_range(0, 99);
				if (pick < 15)
					send_request(read_req(SLOT_W'($urandom)));
				else if (pick < 22)
					send_request(observe_req(random_address(), KIND_W'($urandom),
						RSSI_W'($urandom), stamp));
				else
					send_request(observe_req(pool[$urandom_range(0, pool_size - 1)],
						KIND_W'($urandom), RSSI_W'($urandom), stamp));
				issued++;
			end
		end
		req_valid <= 1'b0;

		while (scoreboard.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run summary: %0d requests; %0d observes, of which %0d refreshed a known device",
			sent_count, scoreboard.observe_count, scoreboard.refresh_count);
		$display("and %0d displaced another one; %0d slot reads; %0d mismatches.",
			scoreboard.replace_count, scoreboard.read_count, scoreboard.mismatches);
		if (scoreboard.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/sdt_pkg.sv
hdl/sdt_cell.sv
hdl/seen_device_table_oldest_replace.sv
dv/sdt_table_scoreboard_pkg.sv
dv/testbench.sv
